// File: src/krsm_pkg.sv
// Shared types, constants and the Shift-JIS conversion for the kanji ROM slot mapper.
package krsm_pkg;

  localparam int ROW_W = 7;
  localparam int CELL_W = 7;
  localparam int CODE_W = 16;
  localparam int OFF_W = 19;

  // Shift-JIS windows of the font image and their base offsets
  localparam logic [CODE_W-1:0] WIN0_LO = 16'h8140;
  localparam logic [CODE_W-1:0] WIN0_HI = 16'h84c0;
  localparam logic [CODE_W-1:0] WIN1_LO = 16'h8890;
  localparam logic [CODE_W-1:0] WIN1_HI = 16'ha000;
  localparam logic [CODE_W-1:0] WIN2_LO = 16'he040;
  localparam logic [CODE_W-1:0] WIN2_HI = 16'heab0;
  localparam logic [OFF_W-1:0] WIN1_BASE = 19'h07000;
  localparam logic [OFF_W-1:0] WIN2_BASE = 19'h35e00;

  // Location of a code in the font image
  typedef struct packed {
    logic             inwin;
    logic [OFF_W-1:0] offset;
  } loc_t;

  // Standard JIS to Shift-JIS rule
  function automatic logic [CODE_W-1:0] to_sjis(input logic [ROW_W-1:0] hi,
                                                 input logic [CELL_W-1:0] lo);
    logic [7:0] h1;
    logic [7:0] s1;
    logic [7:0] s2;
    h1 = ({1'b0, hi} + 8'd1) >> 1;
    s1 = h1 + ((hi <= 7'h5e) ? 8'h70 : 8'hb0);
    if (hi[0]) begin
      s2 = {1'b0, lo} + ((lo < 7'h60) ? 8'h1f : 8'h20);
    end else begin
      s2 = {1'b0, lo} + 8'h7e;
    end
    return {s1, s2};
  endfunction

endpackage

// File: src/krsm_in_if.sv
// Input channel: one JIS code as row and cell.
interface krsm_in_if import krsm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ROW_W-1:0]  row;
  logic [CELL_W-1:0] cell_req;

  modport source (output valid, row, cell_req, input ready);
  modport sink (input valid, row, cell_req, output ready);
endinterface

// File: src/krsm_out_if.sv
// Result channel: presence, glyph slot offset and swapped codes.
interface krsm_out_if import krsm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              present;
  logic [OFF_W-1:0]  glyph_offset;
  logic [CODE_W-1:0] font_jis;
  logic [CODE_W-1:0] font_sjis;

  modport source (output valid, present, glyph_offset, font_jis, font_sjis, input ready);
  modport sink (input valid, present, glyph_offset, font_jis, font_sjis, output ready);
endinterface

// File: src/krsm_locate.sv
// Shift-JIS window lookup and glyph slot offset.
module krsm_locate import krsm_pkg::*; (
  input  logic [ROW_W-1:0]  row,
  input  logic [CELL_W-1:0] cell_byte,
  output loc_t              loc
);

  logic [CODE_W-1:0] sjis;
  logic [CODE_W-1:0] diff0;
  logic [CODE_W-1:0] diff1;
  logic [CODE_W-1:0] diff2;

  assign sjis  = to_sjis(row, cell_byte);
  assign diff0 = sjis - WIN0_LO;
  assign diff1 = sjis - WIN1_LO;
  assign diff2 = sjis - WIN2_LO;

  // Pick the window, first match wins
  always_comb begin
    loc.inwin  = 1'b1;
    loc.offset = '0;
    priority if (sjis >= WIN0_LO && sjis < WIN0_HI) begin
      loc.offset = {diff0[13:0], 5'b0};
    end else if (sjis >= WIN1_LO && sjis < WIN1_HI) begin
      loc.offset = WIN1_BASE + {diff1[13:0], 5'b0};
    end else if (sjis >= WIN2_LO && sjis < WIN2_HI) begin
      loc.offset = WIN2_BASE + {diff2[13:0], 5'b0};
    end else begin
      loc.inwin = 1'b0;
    end
  end

endmodule

// File: src/krsm_valid.sv
// Valid-character check: deleted cell ranges per row and invalid rows.
module krsm_valid import krsm_pkg::*; (
  input  logic [ROW_W-1:0]  row,
  input  logic [CELL_W-1:0] cell_byte,
  output logic              valid_chr
);

  // Deleted cell ranges [lo, hi) for rows 0x22..0x2d, relative to cell 0x20
  localparam logic [6:0] DEL_LO [12][4] = '{
    '{7'h0f, 7'h00, 7'h00, 7'h00},
    '{7'h01, 7'h1a, 7'h3b, 7'h5b},
    '{7'h54, 7'h00, 7'h00, 7'h00},
    '{7'h57, 7'h00, 7'h00, 7'h00},
    '{7'h19, 7'h39, 7'h00, 7'h00},
    '{7'h22, 7'h52, 7'h00, 7'h00},
    '{7'h01, 7'h00, 7'h00, 7'h00},
    '{7'h01, 7'h00, 7'h00, 7'h00},
    '{7'h01, 7'h00, 7'h00, 7'h00},
    '{7'h01, 7'h00, 7'h00, 7'h00},
    '{7'h01, 7'h00, 7'h00, 7'h00},
    '{7'h1f, 7'h37, 7'h5d, 7'h00}
  };
  localparam logic [6:0] DEL_HI [12][4] = '{
    '{7'h5f, 7'h00, 7'h00, 7'h00},
    '{7'h10, 7'h21, 7'h41, 7'h5f},
    '{7'h5f, 7'h00, 7'h00, 7'h00},
    '{7'h5f, 7'h00, 7'h00, 7'h00},
    '{7'h21, 7'h5f, 7'h00, 7'h00},
    '{7'h31, 7'h5f, 7'h00, 7'h00},
    '{7'h5f, 7'h00, 7'h00, 7'h00},
    '{7'h5f, 7'h00, 7'h00, 7'h00},
    '{7'h5f, 7'h00, 7'h00, 7'h00},
    '{7'h5f, 7'h00, 7'h00, 7'h00},
    '{7'h5f, 7'h00, 7'h00, 7'h00},
    '{7'h20, 7'h3f, 7'h5f, 7'h00}
  };

  logic [6:0] row_ofs;
  logic [3:0] idx;
  logic [6:0] dcell;
  logic       deleted;

  assign row_ofs = row - 7'h22;
  assign idx     = row_ofs[3:0];
  assign dcell   = cell_byte - 7'h20;

  // Match the cell against the four ranges of its row
  always_comb begin
    deleted = 1'b0;
    if (row >= 7'h22 && row <= 7'h2d) begin
      for (int k = 0; k < 4; k++) begin
        if (dcell >= DEL_LO[idx][k] && dcell < DEL_HI[idx][k]) begin
          deleted = 1'b1;
        end
      end
    end
  end

  // Row rules, first match wins
  always_comb begin
    priority if (row >= 7'h22 && row <= 7'h2d) begin
      valid_chr = (cell_byte < 7'h20) || !deleted;
    end else if (row == 7'h4f) begin
      valid_chr = cell_byte < 7'h54;
    end else if (row == 7'h7c) begin
      valid_chr = (cell_byte != 7'h6f) && (cell_byte != 7'h70);
    end else if (row == 7'h2e || row == 7'h2f || (row >= 7'h74 && row <= 7'h78) ||
                 row >= 7'h7d) begin
      valid_chr = 1'b0;
    end else begin
      valid_chr = 1'b1;
    end
  end

endmodule

// File: src/krsm_swap.sv
// Code swap through the 1978/1983 and 1983/1990 pair tables, then Shift-JIS.
module krsm_swap import krsm_pkg::*; (
  input  logic [ROW_W-1:0]  row,
  input  logic [CELL_W-1:0] cell_byte,
  output logic [CODE_W-1:0] font_jis,
  output logic [CODE_W-1:0] font_sjis
);

  localparam logic [CODE_W-1:0] SW78_A [4] = '{16'h3646, 16'h4b6a, 16'h4d5a, 16'h596a};
  localparam logic [CODE_W-1:0] SW78_B [4] = '{16'h7421, 16'h7422, 16'h7423, 16'h7424};
  localparam logic [CODE_W-1:0] SW90_A [22] = '{
    16'h724d, 16'h7274, 16'h695a, 16'h5978, 16'h635e, 16'h5e75, 16'h6b5d, 16'h7074,
    16'h6268, 16'h6922, 16'h7057, 16'h6c4d, 16'h5464, 16'h626a, 16'h5b6d, 16'h5e39,
    16'h6d6e, 16'h6a24, 16'h5b58, 16'h5056, 16'h692e, 16'h6446
  };
  localparam logic [CODE_W-1:0] SW90_B [22] = '{
    16'h3033, 16'h3229, 16'h3342, 16'h3349, 16'h3376, 16'h3443, 16'h3452, 16'h375b,
    16'h395c, 16'h3c49, 16'h3f59, 16'h4128, 16'h445b, 16'h4557, 16'h456e, 16'h4573,
    16'h4676, 16'h4768, 16'h4930, 16'h4b79, 16'h4c79, 16'h4f36
  };

  logic [CODE_W-1:0] jis;
  logic [CODE_W-1:0] jis78;
  logic [CODE_W-1:0] jis90;

  assign jis = {1'b0, row, 1'b0, cell_byte};

  // First table: scan from the end so the earliest matching pair wins
  always_comb begin
    jis78 = jis;
    for (int k = 3; k >= 0; k--) begin
      if (jis == SW78_A[k]) begin
        jis78 = SW78_B[k];
      end else if (jis == SW78_B[k]) begin
        jis78 = SW78_A[k];
      end
    end
  end

  // Second table on the result of the first
  always_comb begin
    jis90 = jis78;
    for (int k = 21; k >= 0; k--) begin
      if (jis78 == SW90_A[k]) begin
        jis90 = SW90_B[k];
      end else if (jis78 == SW90_B[k]) begin
        jis90 = SW90_A[k];
      end
    end
  end

  assign font_jis  = jis90;
  assign font_sjis = to_sjis(jis90[14:8], jis90[6:0]);

endmodule

// File: src/kanji_rom_slot_mapper_unit.sv
// Kanji ROM slot mapper top level: input register, mapping logic, result register.
//
// Takes one JIS X 0208 code (row and cell) per transaction and returns one result: a present
// flag, the byte offset of the code's 32-byte glyph slot in the font image, and the code after
// the 1978/1983 and 1983/1990 swaps in JIS and Shift-JIS form. Codes outside the three
// Shift-JIS windows or failing the valid-character rules come back with present low and all
// other fields zero. The block takes one transaction per cycle while the result side drains; a result
// passes from the input register through the single stage of table logic into the result register
// before it is presented. Stalls on the result side back up through both registers.
module kanji_rom_slot_mapper_unit import krsm_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  krsm_in_if.sink    in_ch,
  krsm_out_if.source out_ch
);

  logic              adv;
  logic              in_take;
  logic              s1_vld_r;
  logic              s1_vld_nxt;
  logic [ROW_W-1:0]  row_r;
  logic [ROW_W-1:0]  row_nxt;
  logic [CELL_W-1:0] cell_r;
  logic [CELL_W-1:0] cell_nxt;
  logic              out_vld_r;
  logic              out_vld_nxt;
  logic              present_r;
  logic              present_nxt;
  logic [OFF_W-1:0]  offset_r;
  logic [OFF_W-1:0]  offset_nxt;
  logic [CODE_W-1:0] jis_r;
  logic [CODE_W-1:0] jis_nxt;
  logic [CODE_W-1:0] sjis_r;
  logic [CODE_W-1:0] sjis_nxt;

  loc_t              loc;
  logic              valid_chr;
  logic              hit;
  logic [CODE_W-1:0] font_jis;
  logic [CODE_W-1:0] font_sjis;

  // Advance the pipe when the result register is free or being drained
  assign adv          = !out_vld_r || out_ch.ready;
  assign in_ch.ready  = adv || !s1_vld_r;
  assign in_take      = in_ch.valid && in_ch.ready;

  krsm_locate u_locate (
    .row       (row_r),
    .cell_byte (cell_r),
    .loc       (loc)
  );

  krsm_valid u_valid (
    .row       (row_r),
    .cell_byte (cell_r),
    .valid_chr (valid_chr)
  );

  krsm_swap u_swap (
    .row       (row_r),
    .cell_byte (cell_r),
    .font_jis  (font_jis),
    .font_sjis (font_sjis)
  );

  assign hit = loc.inwin && valid_chr;

  // Next values of the input and result registers
  always_comb begin
    s1_vld_nxt  = s1_vld_r;
    row_nxt     = row_r;
    cell_nxt    = cell_r;
    out_vld_nxt = out_vld_r;
    present_nxt = present_r;
    offset_nxt  = offset_r;
    jis_nxt     = jis_r;
    sjis_nxt    = sjis_r;
    if (adv) begin
      out_vld_nxt = s1_vld_r;
      present_nxt = hit;
      offset_nxt  = hit ? loc.offset : '0;
      jis_nxt     = hit ? font_jis : '0;
      sjis_nxt    = hit ? font_sjis : '0;
    end
    if (adv || !s1_vld_r) begin
      s1_vld_nxt = in_take;
    end
    if (in_take) begin
      row_nxt  = in_ch.row;
      cell_nxt = in_ch.cell_req;
    end
  end

  // Hold control state under reset; payload needs none
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      s1_vld_r  <= s1_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    row_r     <= row_nxt;
    cell_r    <= cell_nxt;
    present_r <= present_nxt;
    offset_r  <= offset_nxt;
    jis_r     <= jis_nxt;
    sjis_r    <= sjis_nxt;
  end

  assign out_ch.valid        = out_vld_r;
  assign out_ch.present      = present_r;
  assign out_ch.glyph_offset = offset_r;
  assign out_ch.font_jis     = jis_r;
  assign out_ch.font_sjis    = sjis_r;

endmodule

// File: bench/kanji_rom_slot_mapper_unit_test.sv
// Self-checking bench for the kanji ROM slot mapper: directed codes, random codes, back-pressure.
`timescale 1ns / 1ps

module kanji_rom_slot_mapper_unit_test;
  import krsm_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 300;
  localparam int PAIR_COUNT = 26;

  // Swap pairs: the first four are the 1978/1983 table, the rest the 1983/1990 table
  localparam logic [PAIR_COUNT*32-1:0] PAIR_CODES = {
    16'h3646, 16'h7421, 16'h4b6a, 16'h7422, 16'h4d5a, 16'h7423, 16'h596a, 16'h7424,
    16'h724d, 16'h3033, 16'h7274, 16'h3229, 16'h695a, 16'h3342, 16'h5978, 16'h3349,
    16'h635e, 16'h3376, 16'h5e75, 16'h3443, 16'h6b5d, 16'h3452, 16'h7074, 16'h375b,
    16'h6268, 16'h395c, 16'h6922, 16'h3c49, 16'h7057, 16'h3f59, 16'h6c4d, 16'h4128,
    16'h5464, 16'h445b, 16'h626a, 16'h4557, 16'h5b6d, 16'h456e, 16'h5e39, 16'h4573,
    16'h6d6e, 16'h4676, 16'h6a24, 16'h4768, 16'h5b58, 16'h4930, 16'h5056, 16'h4b79,
    16'h692e, 16'h4c79, 16'h6446, 16'h4f36
  };

  typedef struct packed {
    logic              present;
    logic [OFF_W-1:0]  glyph_offset;
    logic [CODE_W-1:0] font_jis;
    logic [CODE_W-1:0] font_sjis;
  } glyph_slot_t;

  logic clk;
  logic rst_n;

  krsm_in_if  in_ch ();
  krsm_out_if out_ch ();

  kanji_rom_slot_mapper_unit DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  glyph_slot_t pending_slots[$];
  int send_idle_pct = 27;
  int recv_idle_pct = 50;
  int hold_id = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int codes_sent = 0;
  int results_checked = 0;
  int present_count = 0;
  int error_count = 0;
  int cycle_count = 0;

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Bound the run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $realtime, pending_slots.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic logic [CODE_W-1:0] pair_code(input int idx);
    return PAIR_CODES[(PAIR_COUNT*2-1-idx)*16 +: 16];
  endfunction

  // Standard JIS to Shift-JIS rule, on whole bytes
  function automatic logic [CODE_W-1:0] sjis_of(input logic [CODE_W-1:0] code);
    int hi;
    int lo;
    int s1;
    int s2;
    hi = code[15:8];
    lo = code[7:0];
    s1 = ((hi + 1) >> 1) + ((hi <= 'h5e) ? 'h70 : 'hb0);
    if (hi % 2 == 1) begin
      s2 = lo + ((lo < 'h60) ? 'h1f : 'h20);
    end else begin
      s2 = lo + 'h7e;
    end
    return CODE_W'(((s1 << 8) + s2) & 'hffff);
  endfunction

  function automatic bit in_span(input int d, input int lo, input int hi);
    return d >= lo && d < hi;
  endfunction

  // Deleted cell ranges of rows 0x22..0x2d, cell given relative to 0x20
  function automatic bit cell_deleted(input int r, input int d);
    case (r)
      'h22: return in_span(d, 'h0f, 'h5f);
      'h23: return in_span(d, 'h01, 'h10) || in_span(d, 'h1a, 'h21) ||
                   in_span(d, 'h3b, 'h41) || in_span(d, 'h5b, 'h5f);
      'h24: return in_span(d, 'h54, 'h5f);
      'h25: return in_span(d, 'h57, 'h5f);
      'h26: return in_span(d, 'h19, 'h21) || in_span(d, 'h39, 'h5f);
      'h27: return in_span(d, 'h22, 'h31) || in_span(d, 'h52, 'h5f);
      'h2d: return in_span(d, 'h1f, 'h20) || in_span(d, 'h37, 'h3f) || in_span(d, 'h5d, 'h5f);
      default: return in_span(d, 'h01, 'h5f);
    endcase
  endfunction

  function automatic bit code_allowed(input int r, input int c);
    if (r >= 'h22 && r <= 'h2d) begin
      if (c < 'h20) return 1'b1;
      return !cell_deleted(r, c - 'h20);
    end
    if (r == 'h4f) return c < 'h54;
    if (r == 'h7c) return c != 'h6f && c != 'h70;
    if (r == 'h2e || r == 'h2f || (r >= 'h74 && r <= 'h78) || r >= 'h7d) return 1'b0;
    return 1'b1;
  endfunction

  // First matching pair wins; no match passes the code through
  function automatic logic [CODE_W-1:0] swap_through(input logic [CODE_W-1:0] code,
                                                     input int first, input int count);
    logic [CODE_W-1:0] a;
    logic [CODE_W-1:0] b;
    for (int k = first; k < first + count; k++) begin
      a = pair_code(2 * k);
      b = pair_code(2 * k + 1);
      if (code == a) return b;
      if (code == b) return a;
    end
    return code;
  endfunction

  function automatic glyph_slot_t predict_slot(input logic [ROW_W-1:0] r,
                                               input logic [CELL_W-1:0] c);
    glyph_slot_t slot;
    logic [CODE_W-1:0] code;
    logic [OFF_W-1:0] off;
    int sj;
    bit hit;
    slot = '0;
    code = {1'b0, r, 1'b0, c};
    sj = sjis_of(code);
    hit = 1'b1;
    off = '0;
    // Locate the slot in one of the three font windows
    if (sj >= 'h8140 && sj < 'h84c0) begin
      off = OFF_W'((sj - 'h8140) << 5);
    end else if (sj >= 'h8890 && sj < 'ha000) begin
      off = OFF_W'('h07000 + ((sj - 'h8890) << 5));
    end else if (sj >= 'he040 && sj < 'heab0) begin
      off = OFF_W'('h35e00 + ((sj - 'he040) << 5));
    end else begin
      hit = 1'b0;
    end
    if (hit && code_allowed(r, c)) begin
      code = swap_through(code, 0, 4);
      code = swap_through(code, 4, PAIR_COUNT - 4);
      slot.present = 1'b1;
      slot.glyph_offset = off;
      slot.font_jis = code;
      slot.font_sjis = sjis_of(code);
    end
    return slot;
  endfunction

  // Offer one code, hold it until the block takes it, then record its expected slot
  task automatic send_code(input logic [ROW_W-1:0] r, input logic [CELL_W-1:0] c);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.row <= r;
    in_ch.cell_req <= c;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    pending_slots.push_back(predict_slot(r, c));
    codes_sent++;
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (pending_slots.size() != 0) @(posedge clk);
  endtask

  task automatic report_mismatch(input string field, input int exp_val, input int act_val);
    $display("%0t: %s mismatch, expected %h actual %h", $realtime, field, exp_val, act_val);
    error_count++;
  endtask

  task automatic check_result();
    glyph_slot_t exp_slot;
    if (pending_slots.size() == 0) begin
      $display("%0t: unexpected result, expected none actual present=%b offset=%h jis=%h",
               $realtime, out_ch.present, out_ch.glyph_offset, out_ch.font_jis);
      error_count++;
      return;
    end
    exp_slot = pending_slots.pop_front();
    results_checked++;
    if (exp_slot.present) present_count++;
    if (out_ch.present !== exp_slot.present)
      report_mismatch("present", exp_slot.present, out_ch.present);
    if (out_ch.glyph_offset !== exp_slot.glyph_offset)
      report_mismatch("glyph_offset", exp_slot.glyph_offset, out_ch.glyph_offset);
    if (out_ch.font_jis !== exp_slot.font_jis)
      report_mismatch("font_jis", exp_slot.font_jis, out_ch.font_jis);
    if (out_ch.font_sjis !== exp_slot.font_sjis)
      report_mismatch("font_sjis", exp_slot.font_sjis, out_ch.font_sjis);
  endtask

  // Check each result transaction, then choose the next ready level
  always @(posedge clk) begin
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      check_result();
    end
    if (hold_seen != hold_id) begin
      hold_left = HOLD_CYCLES;
      hold_seen = hold_id;
    end
    if (hold_left > 0) begin
      out_ch.ready <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Window edges, extremes of both bytes, validity rules and swap pairs
  task automatic test_directed_codes();
    send_code(7'h00, 7'h00); send_code(7'h7f, 7'h7f);
    send_code(7'h00, 7'h7f); send_code(7'h7f, 7'h00);
    // first and last slot of the low window, codes in the other two, the start of the high one
    send_code(7'h21, 7'h21); send_code(7'h28, 7'h41);
    send_code(7'h30, 7'h21); send_code(7'h5f, 7'h21);
    send_code(7'h74, 7'h26);
    // deleted-range rows: cell below 0x20, inside and just outside a range
    send_code(7'h22, 7'h1f); send_code(7'h22, 7'h2f);
    send_code(7'h2d, 7'h3f); send_code(7'h2d, 7'h3e);
    // rows with cut-off cells and fully invalid rows
    send_code(7'h4f, 7'h53); send_code(7'h4f, 7'h54);
    send_code(7'h7c, 7'h6f); send_code(7'h7c, 7'h70);
    send_code(7'h2e, 7'h21); send_code(7'h7d, 7'h21);
    // swaps from the first table and from either side of the second table
    send_code(7'h36, 7'h46); send_code(7'h72, 7'h4d);
    send_code(7'h30, 7'h33); send_code(7'h64, 7'h46);
    wait_drained();
  endtask

  // Mostly codes inside the JIS range, some swap codes, deleted-range rows and raw bytes
  task automatic test_random_codes(input int count, input int send_pct, input int recv_pct);
    logic [CODE_W-1:0] code;
    logic [ROW_W-1:0] r;
    logic [CELL_W-1:0] c;
    int pick;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if (pick < 10) begin
        code = pair_code($urandom_range(PAIR_COUNT * 2 - 1));
        r = code[14:8];
        c = code[6:0];
      end else if (pick < 75) begin
        r = ROW_W'($urandom_range(126, 33));
        c = CELL_W'($urandom_range(126, 33));
      end else if (pick < 85) begin
        r = ROW_W'($urandom_range(45, 34));
        c = CELL_W'($urandom_range(127, 0));
      end else begin
        r = ROW_W'($urandom_range(127, 0));
        c = CELL_W'($urandom_range(127, 0));
      end
      send_code(r, c);
    end
    wait_drained();
  endtask

  // Hold off the receiver while codes keep coming, so the block stalls its input
  task automatic test_output_stall();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_id = hold_id + 1;
    for (int n = 0; n < 40; n++) begin
      send_code(ROW_W'($urandom_range(126, 33)), CELL_W'($urandom_range(126, 33)));
    end
    wait_drained();
  endtask

  initial begin
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.row <= '0;
    in_ch.cell_req <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_codes();
    test_random_codes(300, 27, 50);
    test_output_stall();
    test_random_codes(300, 50, 27);
    test_random_codes(300, 0, 0);

    wait_drained();
    repeat (8) @(posedge clk);
    $display("Sent %0d codes, checked %0d results (%0d present).",
             codes_sent, results_checked, present_count);
    $display("Covered window edges, validity rules, both swap tables, stalls and back-pressure.");
    if (error_count == 0 && pending_slots.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// File: filelist.f
src/krsm_pkg.sv
src/krsm_in_if.sv
src/krsm_out_if.sv
src/krsm_locate.sv
src/krsm_valid.sv
src/krsm_swap.sv
src/kanji_rom_slot_mapper_unit.sv
bench/kanji_rom_slot_mapper_unit_test.sv
